// ===== design/sipq_pkg.sv =====
`timescale 1ns / 1ps

package sipq_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ   = 2'd0,
    MODE_DEQ   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_VIEW  = 2'd3
  } mode_t;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ENQ,
    OP_FULL,
    OP_DEQ,
    OP_CLEAR,
    OP_EMPTY,
    OP_VIEW_START,
    OP_VIEW_STEP
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic view_last;
  } stat_t;

endpackage

// ===== design/sipq_in_if.sv =====
`timescale 1ns / 1ps

interface sipq_in_if;
  import sipq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic signed [KEY_W-1:0] key;
  logic [PAY_W-1:0]        payload;

  modport source (output valid, output mode, output key, output payload, input ready);
  modport sink   (input valid, input mode, input key, input payload, output ready);
endinterface

// ===== design/sipq_out_if.sv =====
`timescale 1ns / 1ps

interface sipq_out_if;
  import sipq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [KEY_W-1:0] entry_key;
  logic [PAY_W-1:0]        entry_payload;
  logic [POS_W-1:0]        position;
  logic [POS_W-1:0]        count;
  logic                    last;

  modport source (output valid, output status, output entry_key, output entry_payload,
                  output position, output count, output last, input ready);
  modport sink   (input valid, input status, input entry_key, input entry_payload,
                  input position, input count, input last, output ready);
endinterface

// ===== design/sipq_ctrl.sv =====
`timescale 1ns / 1ps

module sipq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [sipq_pkg::MODE_W-1:0] in_mode,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sipq_pkg::cmd_t              cmd,
  input  sipq_pkg::stat_t             stat
);
  import sipq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_VIEW
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit;
  logic   out_free;

  // output register can take a new result this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    emit       = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          emit = 1'b1;
          case (mode_t'(in_mode))
            MODE_ENQ:   cmd.op = stat.full ? OP_FULL : OP_ENQ;
            MODE_DEQ:   cmd.op = stat.empty ? OP_EMPTY : OP_DEQ;
            MODE_CLEAR: cmd.op = OP_CLEAR;
            MODE_VIEW: begin
              if (stat.empty) begin
                cmd.op = OP_EMPTY;
              end else begin
                cmd.op     = OP_VIEW_START;
                emit       = 1'b0;
                state_next = S_VIEW;
              end
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      S_VIEW: begin
        if (out_free) begin
          cmd.op = OP_VIEW_STEP;
          emit   = 1'b1;
          if (stat.view_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/sipq_dp.sv =====
`timescale 1ns / 1ps

module sipq_dp #(
  parameter int DEPTH = sipq_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sipq_pkg::cmd_t                 cmd,
  output sipq_pkg::stat_t                stat,
  input  logic signed [sipq_pkg::KEY_W-1:0] in_key,
  input  logic [sipq_pkg::PAY_W-1:0]     in_payload,
  output logic [sipq_pkg::STATUS_W-1:0]  status,
  output logic signed [sipq_pkg::KEY_W-1:0] entry_key,
  output logic [sipq_pkg::PAY_W-1:0]     entry_payload,
  output logic [sipq_pkg::POS_W-1:0]     position,
  output logic [sipq_pkg::POS_W-1:0]     count,
  output logic                           last
);
  import sipq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic signed [KEY_W-1:0] slot_key      [DEPTH];
  logic [PAY_W-1:0]        slot_pay      [DEPTH];
  logic signed [KEY_W-1:0] slot_key_next [DEPTH];
  logic [PAY_W-1:0]        slot_pay_next [DEPTH];

  logic [CNT_W-1:0] fill;
  logic [IDX_W-1:0] view_idx;
  logic [CNT_W-1:0] view_pos;
  logic [DEPTH-1:0] gt;

  assign view_pos       = CNT_W'(view_idx) + CNT_W'(1);
  assign stat.empty     = (fill == '0);
  assign stat.full      = (fill == CNT_W'(DEPTH));
  assign stat.view_last = (view_pos == fill);

  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    logic signed [KEY_W-1:0] dn_key;
    logic signed [KEY_W-1:0] up_key;
    logic [PAY_W-1:0]        dn_pay;
    logic [PAY_W-1:0]        up_pay;
    logic                    prev_gt;
    logic                    tail;

    if (g == 0) begin : g_head
      assign dn_key  = in_key;
      assign dn_pay  = in_payload;
      assign prev_gt = 1'b0;
    end else begin : g_body
      assign dn_key  = slot_key[g-1];
      assign dn_pay  = slot_pay[g-1];
      assign prev_gt = gt[g-1];
    end

    // the last slot wraps to the front for the view rotation
    if (g == DEPTH - 1) begin : g_end
      assign up_key = slot_key[0];
      assign up_pay = slot_pay[0];
    end else begin : g_mid
      assign up_key = slot_key[g+1];
      assign up_pay = slot_pay[g+1];
    end

    assign gt[g] = (CNT_W'(g) < fill) && (slot_key[g] > in_key);
    assign tail  = (CNT_W'(g) + CNT_W'(1) == fill);

    always_comb begin
      slot_key_next[g] = slot_key[g];
      slot_pay_next[g] = slot_pay[g];
      case (cmd.op)
        OP_ENQ: begin
          if (prev_gt) begin
            slot_key_next[g] = dn_key;
            slot_pay_next[g] = dn_pay;
          end else if (gt[g] || (CNT_W'(g) == fill)) begin
            slot_key_next[g] = in_key;
            slot_pay_next[g] = in_payload;
          end
        end
        OP_DEQ: begin
          slot_key_next[g] = up_key;
          slot_pay_next[g] = up_pay;
        end
        OP_VIEW_STEP: begin
          // rotate the occupied slots by one, front goes to the tail
          if (tail) begin
            slot_key_next[g] = slot_key[0];
            slot_pay_next[g] = slot_pay[0];
          end else begin
            slot_key_next[g] = up_key;
            slot_pay_next[g] = up_pay;
          end
        end
        default: begin
          slot_key_next[g] = slot_key[g];
          slot_pay_next[g] = slot_pay[g];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_key[i] <= slot_key_next[i];
      slot_pay[i] <= slot_pay_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      view_idx <= '0;
    end else begin
      case (cmd.op)
        OP_ENQ:        fill     <= fill + CNT_W'(1);
        OP_DEQ:        fill     <= fill - CNT_W'(1);
        OP_CLEAR:      fill     <= '0;
        OP_VIEW_START: view_idx <= '0;
        OP_VIEW_STEP:  view_idx <= view_idx + IDX_W'(1);
        default:       fill     <= fill;
      endcase
    end
  end

  // result register, loaded whenever a result is produced
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ENQ: begin
        status        <= STATUS_OK;
        entry_key     <= in_key;
        entry_payload <= in_payload;
        position      <= '0;
        count         <= POS_W'(fill + CNT_W'(1));
        last          <= 1'b1;
      end
      OP_FULL: begin
        status        <= STATUS_FULL;
        entry_key     <= in_key;
        entry_payload <= in_payload;
        position      <= '0;
        count         <= POS_W'(fill);
        last          <= 1'b1;
      end
      OP_DEQ: begin
        status        <= STATUS_OK;
        entry_key     <= slot_key[0];
        entry_payload <= slot_pay[0];
        position      <= '0;
        count         <= POS_W'(fill - CNT_W'(1));
        last          <= 1'b1;
      end
      OP_CLEAR: begin
        status        <= STATUS_OK;
        entry_key     <= '0;
        entry_payload <= '0;
        position      <= '0;
        count         <= '0;
        last          <= 1'b1;
      end
      OP_EMPTY: begin
        status        <= STATUS_EMPTY;
        entry_key     <= '0;
        entry_payload <= '0;
        position      <= '0;
        count         <= '0;
        last          <= 1'b1;
      end
      OP_VIEW_STEP: begin
        status        <= STATUS_OK;
        entry_key     <= slot_key[0];
        entry_payload <= slot_pay[0];
        position      <= POS_W'(view_pos);
        count         <= POS_W'(fill);
        last          <= stat.view_last;
      end
      default: begin
        status <= status;
      end
    endcase
  end

endmodule

// ===== design/sorted_insert_priority_queue_top.sv =====
`timescale 1ns / 1ps

// channel  role    transfer when        payload
// in_ch    sink    valid && ready       mode, key, payload
// out_ch   source  valid && ready       status, entry_key, entry_payload, position, count, last
//
// enqueue, dequeue and clear each give one result from the output register
// a view first resets its index, then gives one result per held entry, rotating the slot row
// the next item is taken once no view is running and the result register is free or being drained
// synchronous active-high rst empties the queue; slot contents are not cleared
// a stalled out_ch holds the result and stops the view rotation

module sorted_insert_priority_queue_top #(
  parameter int DEPTH = sipq_pkg::DEPTH_DEFAULT
) (
  input logic  clk,
  input logic  rst,
  sipq_in_if.sink    in_ch,
  sipq_out_if.source out_ch
);
  import sipq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sipq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sipq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_key        (in_ch.key),
    .in_payload    (in_ch.payload),
    .status        (out_ch.status),
    .entry_key     (out_ch.entry_key),
    .entry_payload (out_ch.entry_payload),
    .position      (out_ch.position),
    .count         (out_ch.count),
    .last          (out_ch.last)
  );

endmodule

// ===== test/tb_sorted_insert_priority_queue_top.sv =====
`timescale 1ns / 1ps

module tb_sorted_insert_priority_queue_top;
  import sipq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;

  typedef struct {
    mode_t                   mode;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } queue_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0]        entry_payload;
    logic [POS_W-1:0]        position;
    logic [POS_W-1:0]        count;
    logic                    last;
  } queue_result_t;

  logic clk;
  logic rst;

  sipq_in_if  in_bus ();
  sipq_out_if out_bus ();

  sorted_insert_priority_queue_top #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow copy of the sorted storage
  logic signed [KEY_W-1:0] slot_key [DEPTH];
  logic [PAY_W-1:0]        slot_pay [DEPTH];
  int                      held;

  queue_cmd_t    pending_cmds[$];
  queue_result_t expected_results[$];
  queue_cmd_t    cur_cmd;
  int            total_cmds;
  int            n_accepted;
  int            n_offered;
  int            results_seen;
  int            hold_left;
  logic          hold_armed;
  int            errors;

  task automatic push_cmd(input mode_t m, input logic signed [KEY_W-1:0] k,
                          input logic [PAY_W-1:0] p);
    queue_cmd_t c;
    c.mode    = m;
    c.key     = k;
    c.payload = p;
    pending_cmds.push_back(c);
  endtask

  // updates the shadow queue and appends the results the command causes
  task automatic apply_queue_op(input queue_cmd_t c);
    queue_result_t r;
    int at;
    r.status        = STATUS_OK;
    r.entry_key     = '0;
    r.entry_payload = '0;
    r.position      = '0;
    r.count         = '0;
    r.last          = 1'b1;
    case (c.mode)
      MODE_ENQ: begin
        r.entry_key     = c.key;
        r.entry_payload = c.payload;
        if (held >= DEPTH) begin
          r.status = STATUS_FULL;
          r.count  = POS_W'(held);
        end else begin
          // new entry goes behind all entries with key <= its own
          at = held;
          for (int i = 0; i < held; i++) begin
            if (slot_key[i] > c.key) begin
              at = i;
              break;
            end
          end
          for (int i = held; i > at; i--) begin
            slot_key[i] = slot_key[i-1];
            slot_pay[i] = slot_pay[i-1];
          end
          slot_key[at] = c.key;
          slot_pay[at] = c.payload;
          held++;
          r.count = POS_W'(held);
        end
        expected_results.push_back(r);
      end
      MODE_DEQ: begin
        if (held == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.entry_key     = slot_key[0];
          r.entry_payload = slot_pay[0];
          for (int i = 1; i < held; i++) begin
            slot_key[i-1] = slot_key[i];
            slot_pay[i-1] = slot_pay[i];
          end
          held--;
          r.count = POS_W'(held);
        end
        expected_results.push_back(r);
      end
      MODE_CLEAR: begin
        held = 0;
        expected_results.push_back(r);
      end
      default: begin
        if (held == 0) begin
          r.status = STATUS_EMPTY;
          expected_results.push_back(r);
        end else begin
          for (int i = 0; i < held; i++) begin
            r.entry_key     = slot_key[i];
            r.entry_payload = slot_pay[i];
            r.position      = POS_W'(i + 1);
            r.count         = POS_W'(held);
            r.last          = (i + 1 == held);
            expected_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic offer;
    logic quiet;
    if (rst) begin
      in_bus.valid <= 1'b0;
    end else begin
      offer = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        apply_queue_op(cur_cmd);
        n_accepted <= n_accepted + 1;
        offer = 1'b0;
      end
      // no gaps in a stretch of the sequence, nor while the receiver holds off
      quiet = (n_offered >= 120 && n_offered < 200) || hold_left != 0;
      if (!offer && pending_cmds.size() > 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
        cur_cmd = pending_cmds.pop_front();
        n_offered++;
        in_bus.mode    <= cur_cmd.mode;
        in_bus.key     <= cur_cmd.key;
        in_bus.payload <= cur_cmd.payload;
        offer = 1'b1;
      end
      in_bus.valid <= offer;
    end
  end

  // long receiver hold-off once traffic is under way, so the input backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && n_accepted >= 60) begin
      hold_left  <= 150;
      hold_armed <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    queue_result_t exp_r;
    logic quiet;
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: key 0x%08h status %0d",
                 out_bus.entry_key, out_bus.status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", 32'(exp_r.status), 32'(out_bus.status));
          check_field("entry_key", exp_r.entry_key, out_bus.entry_key);
          check_field("entry_payload", exp_r.entry_payload, out_bus.entry_payload);
          check_field("position", 32'(exp_r.position), 32'(out_bus.position));
          check_field("count", 32'(exp_r.count), 32'(out_bus.count));
          check_field("last", 32'(exp_r.last), 32'(out_bus.last));
        end
      end
      quiet = results_seen >= 250 && results_seen < 450;
      out_bus.ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 15);
    end
  end

  initial begin
    mode_t                   m;
    logic signed [KEY_W-1:0] k;
    int                      enq_pct;
    int                      pick;

    rst            = 1'b1;
    in_bus.valid   = 1'b0;
    in_bus.mode    = MODE_ENQ;
    in_bus.key     = '0;
    in_bus.payload = '0;
    out_bus.ready  = 1'b0;
    held           = 0;
    n_accepted     = 0;
    n_offered      = 0;
    results_seen   = 0;
    errors         = 0;

    // empty queue behavior
    push_cmd(MODE_VIEW, 32'sd7, 32'h1234_5678);
    push_cmd(MODE_DEQ, -32'sd1, 32'hFFFF_FFFF);
    push_cmd(MODE_CLEAR, 32'sd0, 32'h0);
    // fill with extremes and runs of equal keys
    push_cmd(MODE_ENQ, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(MODE_ENQ, 32'sh8000_0000, 32'h0000_0000);
    push_cmd(MODE_ENQ, 32'sd0, 32'hAAAA_AAAA);
    push_cmd(MODE_ENQ, -32'sd1, 32'h5555_5555);
    push_cmd(MODE_ENQ, 32'sd5, 32'h0000_0001);
    push_cmd(MODE_ENQ, 32'sd5, 32'h0000_0002);
    push_cmd(MODE_ENQ, 32'sd5, 32'h0000_0003);
    push_cmd(MODE_ENQ, 32'sh8000_0000, 32'h8000_0000);
    push_cmd(MODE_ENQ, 32'sh7FFF_FFFF, 32'h7FFF_FFFF);
    push_cmd(MODE_ENQ, 32'sd1, 32'hDEAD_BEEF);
    push_cmd(MODE_ENQ, -32'sd5, 32'h0F0F_0F0F);
    push_cmd(MODE_ENQ, 32'sd0, 32'hF0F0_F0F0);
    push_cmd(MODE_ENQ, 32'sh4000_0000, 32'h0000_FFFF);
    push_cmd(MODE_ENQ, -32'sh4000_0000, 32'hFFFF_0000);
    push_cmd(MODE_ENQ, 32'sd5, 32'h0000_0004);
    push_cmd(MODE_ENQ, -32'sd1, 32'h1111_1111);
    // full: dropped even though its key ties the smallest key held
    push_cmd(MODE_ENQ, 32'sh8000_0000, 32'hCAFE_F00D);
    push_cmd(MODE_VIEW, 32'sd0, 32'h0);
    push_cmd(MODE_DEQ, 32'sd0, 32'h0);
    push_cmd(MODE_CLEAR, 32'sd0, 32'h0);
    push_cmd(MODE_VIEW, 32'sd0, 32'h0);
    push_cmd(MODE_DEQ, 32'sd0, 32'h0);

    // random blocks that swing between filling and draining
    for (int b = 0; b < 12; b++) begin
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 55;
        default: enq_pct = 25;
      endcase
      if (b == 0) enq_pct = 85;
      for (int j = 0; j < 25; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) m = MODE_CLEAR;
        else if (pick < 12) m = MODE_VIEW;
        else if ($urandom_range(0, 99) < enq_pct) m = MODE_ENQ;
        else m = MODE_DEQ;
        case ($urandom_range(0, 3))
          0: k = $signed($urandom_range(0, 8)) - 32'sd4;
          1: begin
            case ($urandom_range(0, 3))
              0:       k = 32'sh8000_0000;
              1:       k = 32'sh7FFF_FFFF;
              2:       k = 32'sd0;
              default: k = -32'sd1;
            endcase
          end
          default: k = $urandom();
        endcase
        push_cmd(m, k, $urandom());
      end
    end
    total_cmds = pending_cmds.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < total_cmds) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sipq_pkg.sv
design/sipq_in_if.sv
design/sipq_out_if.sv
design/sipq_ctrl.sv
design/sipq_dp.sv
design/sorted_insert_priority_queue_top.sv
test/tb_sorted_insert_priority_queue_top.sv
